/* rtl/sct_pkg.sv */
package sct_pkg;

  // default width of the byte position counter
  localparam int unsigned POS_BITS_DEF = 16;

  // token kind codes
  localparam logic [3:0] KIND_LAMBDA  = 4'd0;
  localparam logic [3:0] KIND_DEFINE  = 4'd1;
  localparam logic [3:0] KIND_COMMA   = 4'd2;
  localparam logic [3:0] KIND_OPEN    = 4'd3;
  localparam logic [3:0] KIND_CLOSE   = 4'd4;
  localparam logic [3:0] KIND_OPER    = 4'd5;
  localparam logic [3:0] KIND_STRING  = 4'd6;
  localparam logic [3:0] KIND_CHAR    = 4'd7;
  localparam logic [3:0] KIND_NUMBER  = 4'd8;
  localparam logic [3:0] KIND_NEWLINE = 4'd9;
  localparam logic [3:0] KIND_INDENT  = 4'd10;
  localparam logic [3:0] KIND_SPACE   = 4'd11;
  localparam logic [3:0] KIND_IDENT   = 4'd12;

  // special bytes
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_QUOTE  = 8'h27;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] ch;
    logic       block_end;
  } in_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        run_last;
  } out_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_open(input logic [7:0] c);
    return (c == "[") || (c == "(") || (c == "{");
  endfunction

  function automatic logic is_close(input logic [7:0] c);
    return (c == "]") || (c == ")") || (c == "}");
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == ":") || (c == "?") || (c == ",");
  endfunction

  function automatic logic is_single_op(input logic [7:0] c);
    return (c == "~") || (c == ";") || (c == "|") || (c == "&") || (c == "<") ||
           (c == "=") || (c == ">") || (c == "+") || (c == "-") || (c == "*") ||
           (c == "/") || (c == "%") || (c == "^") || (c == CH_QUOTE) ||
           (c == "@") || (c == "#") || (c == "!") || (c == "$") || (c == ":") ||
           (c == "?") || (c == ",") || (c == 8'd32);
  endfunction

  // token kind from first two bytes, length and flags
  function automatic logic [3:0] kind_of(input logic [7:0] f, input logic [7:0] s,
                                         input logic [15:0] len, input logic nl,
                                         input logic tab);
    logic one;
    one = (len == 16'd1);
    if (one && f == "?") return KIND_LAMBDA;
    if (one && f == ":") return KIND_DEFINE;
    if (one && f == ",") return KIND_COMMA;
    if (is_open(f)) return KIND_OPEN;
    if (is_close(f)) return KIND_CLOSE;
    if (one && is_single_op(f)) return KIND_OPER;
    if (len == 16'd2 && s == "=" && (f == "<" || f == ">" || f == "!")) return KIND_OPER;
    if (f == CH_BTICK) return KIND_STRING;
    if (f == CH_BSLASH) return KIND_CHAR;
    if (is_digit(f) || (f == "-" && len > 16'd1 && is_digit(s))) return KIND_NUMBER;
    if (nl) return KIND_NEWLINE;
    if (tab) return KIND_INDENT;
    if (is_space(f)) return KIND_SPACE;
    return KIND_IDENT;
  endfunction

endpackage

/* rtl/source_char_tokenizer_top.sv */
// Source text tokenizer: takes one source byte per word and returns one descriptor word
// per token (kind, start position in the block, length). A byte is accepted every cycle
// while the four-word result queue has room for two more descriptors; a byte that
// finishes two tokens puts two words in the queue, which drain at one per cycle while the
// output is ready, so the sustained rate is one byte per cycle when bytes give at most
// one descriptor each. Descriptors are registered in the queue and leave it in order.
module source_char_tokenizer_top import sct_pkg::*; #(
  parameter int unsigned POSITION_BITS = POS_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned PB = POSITION_BITS;
  localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_STRING,
    MODE_CHAR,
    MODE_INDENT
  } mode_t;

  typedef struct packed {
    logic [PB-1:0] start;
    logic [15:0]   len;
    logic [7:0]    first;
    logic [7:0]    second;
    logic          nl;
    logic          tab;
  } pend_t;

  typedef struct packed {
    logic [1:0] n;
    out_t       d0;
    out_t       d1;
  } emit_t;

  mode_t         mode_r, mode_nxt;
  pend_t         pend_r, pend_nxt;
  logic [PB-1:0] pos_r, pos_nxt;
  emit_t         em;

  out_t          q_r [4];
  out_t          q_nxt [4];
  logic [2:0]    cnt_r, cnt_nxt;
  logic          in_acc, pop;

  // descriptor with start saturated to 16 bits
  function automatic out_t make_desc(input logic [3:0] k, input logic [PB-1:0] st,
                                     input logic [15:0] len);
    out_t d;
    logic [31:0] s32;
    s32 = 32'(st);
    d.token_kind = k;
    d.token_start = (s32 > 32'h0000FFFF) ? 16'hFFFF : s32[15:0];
    d.token_length = len;
    d.run_last = 1'b0;
    return d;
  endfunction

  function automatic out_t pend_desc(input pend_t p);
    return make_desc(kind_of(p.first, p.second, p.len, p.nl, p.tab), p.start, p.len);
  endfunction

  function automatic emit_t emit_add(input emit_t e, input logic v, input out_t d);
    emit_t r;
    r = e;
    if (v) begin
      if (e.n == 2'd0) r.d0 = d;
      else r.d1 = d;
      r.n = e.n + 2'd1;
    end
    return r;
  endfunction

  function automatic pend_t app(input pend_t p, input logic [7:0] c,
                                input logic [PB-1:0] pos);
    pend_t r;
    r = p;
    if (p.len == 16'd0) begin
      r.start = pos;
      r.first = c;
    end else if (p.len == 16'd1) begin
      r.second = c;
    end
    if (p.len != LEN_MAX) r.len = p.len + 16'd1;
    if (c == CH_NL) r.nl = 1'b1;
    if (c == CH_TAB) r.tab = 1'b1;
    return r;
  endfunction

  // handshakes
  assign in_ready  = (cnt_r <= 3'd2);
  assign in_acc    = in_valid & in_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_r[0];
  assign pop       = out_valid & out_ready;

  // lexer step for the incoming byte
  always_comb begin
    logic [7:0] c;
    logic       done;
    pend_t      p;
    emit_t      e;
    c = in_data.ch;
    done = 1'b0;
    p = pend_r;
    e = '0;
    mode_nxt = mode_r;

    unique case (mode_r)
      MODE_STRING: begin
        p = app(p, c, pos_r);
        if (c == CH_BTICK) begin
          e = emit_add(e, p.len != 16'd0, pend_desc(p));
          p = '0;
          mode_nxt = MODE_NORMAL;
        end
        done = 1'b1;
      end
      MODE_CHAR: begin
        p = app(p, c, pos_r);
        e = emit_add(e, p.len != 16'd0, pend_desc(p));
        p = '0;
        mode_nxt = MODE_NORMAL;
        done = 1'b1;
      end
      MODE_INDENT: begin
        if (c == CH_TAB) begin
          p = app(p, c, pos_r);
          done = 1'b1;
        end else begin
          e = emit_add(e, p.len != 16'd0, pend_desc(p));
          p = '0;
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_NORMAL: begin
        mode_nxt = MODE_NORMAL;
      end
      default: begin
        mode_nxt = MODE_NORMAL;
      end
    endcase

    // fresh byte in normal mode, or the byte that ends an indent run
    if (!done) begin
      priority if (c == CH_BTICK) begin
        e = emit_add(e, p.len != 16'd0, pend_desc(p));
        p = app('0, c, pos_r);
        mode_nxt = MODE_STRING;
      end else if (c == CH_BSLASH) begin
        e = emit_add(e, p.len != 16'd0, pend_desc(p));
        p = app('0, c, pos_r);
        mode_nxt = MODE_CHAR;
      end else if (c == CH_NL) begin
        e = emit_add(e, p.len != 16'd0, pend_desc(p));
        p = app('0, c, pos_r);
        mode_nxt = MODE_INDENT;
      end else if (is_space(c)) begin
        e = emit_add(e, p.len != 16'd0, pend_desc(p));
        p = '0;
      end else if (is_open(c) || is_close(c) || is_sep(c)) begin
        e = emit_add(e, p.len != 16'd0, pend_desc(p));
        p = '0;
        e = emit_add(e, 1'b1,
                     make_desc(kind_of(c, 8'd0, 16'd1, 1'b0, 1'b0), pos_r, 16'd1));
      end else begin
        p = app(p, c, pos_r);
      end
    end

    // end of block flushes and restarts positions
    if (in_data.block_end) begin
      e = emit_add(e, p.len != 16'd0, pend_desc(p));
      p = '0;
      mode_nxt = MODE_NORMAL;
      pos_nxt = '0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
    end else begin
      pos_nxt = pos_r;
    end

    // mark the last descriptor of this byte
    e.d0.run_last = (e.n == 2'd1);
    e.d1.run_last = 1'b1;

    pend_nxt = p;
    em = e;
  end

  // result queue: head at entry 0, shifts on pop
  always_comb begin
    logic [2:0] base;
    logic [1:0] wi;
    base = cnt_r - {2'b00, pop};
    for (int i = 0; i < 4; i++) begin
      if (pop && i < 3) q_nxt[i] = q_r[i + 1];
      else q_nxt[i] = q_r[i];
    end
    wi = base[1:0];
    if (in_acc && em.n != 2'd0) q_nxt[wi] = em.d0;
    if (in_acc && em.n == 2'd2) q_nxt[wi + 2'd1] = em.d1;
    cnt_nxt = base + (in_acc ? {1'b0, em.n} : 3'd0);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      pend_r <= '0;
      pos_r  <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        mode_r <= mode_nxt;
        pend_r <= pend_nxt;
        pos_r  <= pos_nxt;
      end
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule
